// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probing hash table
// Field widths, the slot entry layout, the controller state encoding and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int KEY_W     = 31;
  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic pos_home;
    logic pos_inc;
    logic slot_write;
    logic slot_clear;
    logic set_fail;
    logic set_hit;
    logic set_inserted;
    logic out_load;
  } lpht_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic pos_end;
    logic is_search;
    logic slot_used;
    logic key_match;
    logic out_free;
  } lpht_status_t;

endpackage

// ===== rtl/lpht_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_req_if: request channel
// Valid/ready channel carrying one insert or search request per transfer.
// ----------------------------------------------------------------------------
interface lpht_req_if import lpht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink (input valid, action, key, value, output ready);
endinterface

// ===== rtl/lpht_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_rsp_if: response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface lpht_rsp_if import lpht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               status;
  logic [VALUE_W-1:0] found_value;
  logic [COUNT_W-1:0] stored_count;

  modport source (output valid, status, found_value, stored_count, input ready);
  modport sink (input valid, status, found_value, stored_count, output ready);
endinterface

// ===== rtl/lpht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram: generic single-port RAM
// One address shared by write and read; read data is registered.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/lpht_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ctrl: request sequencer
// Runs the clearing pass, the home slot calculation, the slot probing and
// the hand-over of each result to the output register.
// ----------------------------------------------------------------------------
module lpht_ctrl import lpht_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  lpht_status_t status,
  output lpht_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.pos_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        if (status.hash_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = status.pos_end ? ST_RESULT : ST_CHECK;
      end
      ST_CHECK: begin
        if (!status.slot_used || (status.is_search && status.key_match)) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (!status.pos_end) begin
          cmd.slot_write = 1'b1;
          cmd.slot_clear = 1'b1;
          cmd.pos_inc    = 1'b1;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_HASH: begin
        cmd.hash_step = 1'b1;
        cmd.pos_home  = status.hash_last;
      end
      ST_READ: begin
        cmd.set_fail = status.pos_end;
      end
      ST_CHECK: begin
        if (!status.slot_used) begin
          if (status.is_search) begin
            cmd.set_fail = 1'b1;
          end else begin
            cmd.slot_write   = 1'b1;
            cmd.set_inserted = 1'b1;
          end
        end else if (status.is_search && status.key_match) begin
          cmd.set_hit = 1'b1;
        end else begin
          cmd.pos_inc = 1'b1;
        end
      end
      ST_RESULT: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/lpht_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_dp: hash table datapath
// Holds the request, reduces the key modulo the table size with a registered multiply
// and a remainder, walks the probe position over the slot RAM and keeps the result.
// ----------------------------------------------------------------------------
module lpht_dp import lpht_pkg::*; #(
  parameter int TABLE_SIZE = 31
) (
  input  logic               clk,
  input  logic               rst,
  input  lpht_cmd_t          cmd,
  output lpht_status_t       status,
  input  logic               in_action,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_status,
  output logic [VALUE_W-1:0] out_found_value,
  output logic [COUNT_W-1:0] out_stored_count
);

  localparam int AW     = $clog2(TABLE_SIZE);
  localparam int PW     = $clog2(TABLE_SIZE + 1);
  localparam int SHIFT  = KEY_W + AW;
  localparam int PROD_W = KEY_W + 32;
  localparam int QUOT_W = PROD_W - SHIFT;
  localparam logic [PW-1:0] SIZE_P = PW'(TABLE_SIZE);
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];

  logic                 search_q;
  logic [KEY_W-1:0]     key_q;
  logic [VALUE_W-1:0]   value_q;
  logic                 hash_done;
  logic [PROD_W-1:0]    prod;
  logic [QUOT_W-1:0]    quot;
  logic [KEY_W-1:0]     rem_wide;
  logic [AW-1:0]        home;
  logic [PW-1:0]        pos;
  logic [COUNT_W-1:0]   entry_count;
  logic                 res_status;
  logic [VALUE_W-1:0]   res_value;
  entry_t               wr_entry;
  entry_t               rd_entry;
  logic [$bits(entry_t)-1:0] rd_word;

  // The quotient is the key times the rounded-up reciprocal of the table
  // size; with this shift it is exact for every key, so the remainder is
  // the key less the quotient times the table size.
  always_comb begin
    quot     = prod[PROD_W-1:SHIFT];
    rem_wide = key_q - KEY_W'(quot) * KEY_W'(TABLE_SIZE);
    home     = rem_wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      search_q  <= in_action;
      key_q     <= in_key;
      value_q   <= in_value;
      hash_done <= 1'b0;
    end else if (cmd.hash_step) begin
      prod      <= PROD_W'(key_q) * PROD_W'(RECIP);
      hash_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.pos_home) begin
      pos <= PW'(home);
    end else if (cmd.pos_inc) begin
      pos <= pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.set_inserted && entry_count != COUNT_MAX) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_fail) begin
      res_status <= STATUS_FAIL;
      res_value  <= '0;
    end else if (cmd.set_hit) begin
      res_status <= STATUS_OK;
      res_value  <= rd_entry.value;
    end else if (cmd.set_inserted) begin
      res_status <= STATUS_OK;
      res_value  <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status       <= res_status;
      out_found_value  <= res_value;
      out_stored_count <= entry_count;
    end
  end

  always_comb begin
    if (cmd.slot_clear) begin
      wr_entry = '0;
    end else begin
      wr_entry.used  = 1'b1;
      wr_entry.key   = key_q;
      wr_entry.value = value_q;
    end
  end

  lpht_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .addr  (pos[AW-1:0]),
    .we    (cmd.slot_write),
    .wdata (wr_entry),
    .rdata (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  assign status.hash_last = hash_done;
  assign status.pos_end   = (pos == SIZE_P);
  assign status.is_search = (search_q == ACT_SEARCH);
  assign status.slot_used = rd_entry.used;
  assign status.key_match = (rd_entry.key == key_q);
  assign status.out_free  = !out_valid || out_ready;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// A request is taken, its home slot is found (multiply, then remainder), each
// tested slot is read from the RAM and then tested, and the result is loaded
// into the output register; a probe that passes the last slot fails. One
// request is in work at a time; the next is taken while the previous result
// waits in the output register.
// Reset: synchronous; a clearing pass empties every slot with ready low.
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing hash table with linear probing
// Inserts key/value pairs at the first free slot from the home slot upward and
// searches for keys along the same path, without wrap-around.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int TABLE_SIZE = 31
) (
  input  logic      clk,
  input  logic      rst,
  lpht_req_if.sink  req,
  lpht_rsp_if.source rsp
);

  lpht_cmd_t    cmd;
  lpht_status_t status;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_action        (req.action),
    .in_key           (req.key),
    .in_value         (req.value),
    .out_valid        (rsp.valid),
    .out_ready        (rsp.ready),
    .out_status       (rsp.status),
    .out_found_value  (rsp.found_value),
    .out_stored_count (rsp.stored_count)
  );

endmodule

// ===== rtl/lpht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker: port-level checks for the hash table
// Watches the request and response channels and the stored count over time.
// ----------------------------------------------------------------------------
module lpht_checker import lpht_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               rsp_status,
  input logic [VALUE_W-1:0] rsp_found_value,
  input logic [COUNT_W-1:0] rsp_stored_count
);

  logic               req_xfer;
  logic               rsp_xfer;
  logic [1:0]         pending;
  logic [COUNT_W-1:0] last_count;

  assign req_xfer = req_valid && req_ready;
  assign rsp_xfer = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_count <= '0;
    end else begin
      pending <= pending + {1'b0, req_xfer} - {1'b0, rsp_xfer};
      if (rsp_xfer) begin
        last_count <= rsp_stored_count;
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response withdrawn before its transfer");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_found_value)
      && $stable(rsp_stored_count))
    else $error("stalled response payload changed");

  // Every response answers an earlier request transfer.
  a_rsp_has_req: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer |-> pending != 2'd0)
    else $error("response without an outstanding request");

  // The count moves by at most one entry from one response to the next.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rsp_xfer |-> (rsp_stored_count == last_count)
      || (rsp_stored_count == COUNT_W'(last_count + 1'b1)))
    else $error("stored count jumped between responses");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == STATUS_FAIL |-> rsp_found_value == '0)
    else $error("failed request returned a non-zero value");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_found_value  (rsp.found_value),
  .rsp_stored_count (rsp.stored_count)
);

// ===== tb/lpht_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_table_checker: scoreboard for the linear probing hash table
// Watches the request and response channels. It keeps its own copy of the
// slot store and entry count, works out the reply for every accepted request,
// and compares each accepted reply with the oldest outstanding one.
// ----------------------------------------------------------------------------
module lpht_table_checker import lpht_pkg::*; #(
  parameter int TABLE_SIZE = 31
) (
  input  logic clk,
  input  logic rst,
  lpht_req_if  req,
  lpht_rsp_if  rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0] stored_count;
  } table_reply_t;

  logic               slot_taken [TABLE_SIZE];
  logic [KEY_W-1:0]   slot_keys  [TABLE_SIZE];
  logic [VALUE_W-1:0] slot_vals  [TABLE_SIZE];
  logic [COUNT_W-1:0] entries;
  table_reply_t       replies_due [$];

  // Applies one request to the mirrored store and returns the reply it gives.
  function automatic table_reply_t apply_request(input logic act,
                                                 input logic [KEY_W-1:0] k,
                                                 input logic [VALUE_W-1:0] v);
    table_reply_t reply;
    logic [31:0]  wide_key;
    int           slot;
    wide_key            = {1'b0, k};
    slot                = int'(wide_key % TABLE_SIZE);
    reply.status        = STATUS_FAIL;
    reply.found_value   = '0;
    if (act == ACT_INSERT) begin
      while (slot < TABLE_SIZE && slot_taken[slot]) slot++;
      if (slot < TABLE_SIZE) begin
        slot_taken[slot] = 1'b1;
        slot_keys[slot]  = k;
        slot_vals[slot]  = v;
        if (entries != COUNT_MAX) entries = entries + 1'b1;
        reply.status = STATUS_OK;
      end
    end else begin
      while (slot < TABLE_SIZE && slot_taken[slot]) begin
        if (slot_keys[slot] == k) begin
          reply.status      = STATUS_OK;
          reply.found_value = slot_vals[slot];
          break;
        end
        slot++;
      end
    end
    reply.stored_count = entries;
    return reply;
  endfunction

  always @(posedge clk) begin : watch
    table_reply_t want;
    int           pushed;
    int           popped;
    int           errs;
    pushed = 0;
    popped = 0;
    errs   = 0;
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) slot_taken[i] = 1'b0;
      entries = '0;
      replies_due.delete();
      pending    <= 0;
      fail_count <= 0;
    end else begin
      if (req.valid && req.ready) begin
        replies_due.push_back(apply_request(req.action, req.key, req.value));
        pushed = 1;
      end
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t ns: reply with none outstanding, status %0d value 0x%08h count %0d",
                   $time, rsp.status, rsp.found_value, rsp.stored_count);
          errs++;
        end else begin
          want   = replies_due.pop_front();
          popped = 1;
          if (rsp.status !== want.status) begin
            $display("%0t ns: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp.status);
            errs++;
          end
          if (rsp.found_value !== want.found_value) begin
            $display("%0t ns: found_value mismatch, expected 0x%08h, actual 0x%08h",
                     $time, want.found_value, rsp.found_value);
            errs++;
          end
          if (rsp.stored_count !== want.stored_count) begin
            $display("%0t ns: stored_count mismatch, expected %0d, actual %0d",
                     $time, want.stored_count, rsp.stored_count);
            errs++;
          end
        end
      end
      pending    <= pending + pushed - popped;
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for linear_probe_hash_table
// Drives insert and search requests with random gaps, stalls the response
// side at random and twice for a long stretch, and reports the verdict from
// the failure count of the scoreboard beside the block.
// ----------------------------------------------------------------------------
module tb_top import lpht_pkg::*; ();

  localparam int TABLE_SIZE   = 31;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 2 * (5 + 2 * TABLE_SIZE);

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;

  logic [KEY_W-1:0] known_keys [$];

  lpht_req_if req ();
  lpht_rsp_if rsp ();

  linear_probe_hash_table #(.TABLE_SIZE(TABLE_SIZE)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  lpht_table_checker #(.TABLE_SIZE(TABLE_SIZE)) table_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // Mostly short gaps, a few long ones, and a window of back-to-back
  // transfers in every 128.
  function automatic int idle_len(input int n);
    int r;
    if ((n % 128) < 24) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    if ($urandom_range(0, 3) == 0) return KEY_W'($urandom());
    return KEY_W'($urandom_range(0, 300));
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  function automatic logic [VALUE_W-1:0] any_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return VALUE_W'($urandom());
  endfunction

  task automatic offer(input logic act, input logic [KEY_W-1:0] k,
                       input logic [VALUE_W-1:0] v);
    int gap;
    gap = idle_len(sent);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.key    <= k;
    req.value  <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
    if (act == ACT_INSERT) known_keys.push_back(k);
  endtask

  // Holds the request side quiet until every reply has come back.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : response_sink
    int taken;
    int stall;
    taken = 0;
    rsp.ready <= 1'b0;
    forever begin
      stall = idle_len(taken);
      // Long hold-offs let the block fill up and stall its request side.
      if (taken == 40 || taken == 700) stall = 400;
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : request_source
    logic             act;
    logic [KEY_W-1:0] k;
    int               r;
    sent = 0;
    rst        <= 1'b1;
    req.valid  <= 1'b0;
    req.action <= ACT_INSERT;
    req.key    <= '0;
    req.value  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty table, collisions, duplicate keys, the top slot, a full probe
    // run and searches that run off the end.
    offer(ACT_SEARCH, 31'd0, 32'h0);
    offer(ACT_INSERT, 31'd0, 32'hFFFF_FFFF);
    offer(ACT_INSERT, 31'd31, 32'h1234_5678);
    offer(ACT_INSERT, 31'd0, 32'h0);
    offer(ACT_SEARCH, 31'd0, 32'h0);
    offer(ACT_SEARCH, 31'd31, 32'h0);
    offer(ACT_SEARCH, 31'd62, 32'h0);
    offer(ACT_INSERT, 31'd30, 32'hA5A5_A5A5);
    offer(ACT_INSERT, 31'd61, 32'h1);
    offer(ACT_SEARCH, 31'd61, 32'h0);
    offer(ACT_SEARCH, 31'd30, 32'hFFFF_FFFF);
    offer(ACT_INSERT, 31'h7FFF_FFFF, 32'h5A5A_5A5A);
    offer(ACT_SEARCH, 31'h7FFF_FFFF, 32'h0);
    offer(ACT_INSERT, 31'd29, 32'h8000_0001);
    offer(ACT_SEARCH, 31'd60, 32'h0);
    offer(ACT_SEARCH, 31'd29, 32'h0);
    settle();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) settle();
      r = $urandom_range(0, 99);
      if (r < 10) begin
        act = ACT_INSERT;
        k   = ($urandom_range(0, 2) == 0) ? known_key() : fresh_key();
      end else begin
        act = ACT_SEARCH;
        r   = $urandom_range(0, 99);
        if (r < 55) k = known_key();
        else if (r < 75) k = KEY_W'(known_key() + TABLE_SIZE * $urandom_range(1, 1000));
        else k = fresh_key();
      end
      offer(act, k, any_value());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
